>>> hdl/erle_pkg.sv
// shared types, constants and digit helper for the escaped run-length expander
package erle_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned MAX_REPEAT = 63;

  localparam logic [BYTE_W-1:0] BACKSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_CLOSE,
    ST_HELD
  } erle_state_t;

  typedef enum logic [1:0] {
    DIG_HUND,
    DIG_TENS,
    DIG_ONES
  } erle_dpos_t;

  // one byte offered to the output register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } erle_emit_t;

  // decimal digit of a byte at a given position
  function automatic logic [3:0] escape_digit(input logic [BYTE_W-1:0] b,
                                              input erle_dpos_t pos);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [3:0]  res;
    hund = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    rem  = 7'(b - 8'(hund * 7'd100));
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 7'(rem - 7'(tens * 7'd10));
    unique case (pos)
      DIG_HUND: res = {2'b00, hund};
      DIG_TENS: res = tens;
      DIG_ONES: res = ones[3:0];
      default:  res = 4'd0;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/erle_in_if.sv
// request channel carrying source text bytes
interface erle_in_if
  import erle_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> hdl/erle_out_if.sv
// request channel carrying expanded text bytes
interface erle_out_if
  import erle_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hdl/erle_count_unit.sv
// shared multiply-by-ten, add and saturate unit for digit runs
module erle_count_unit
  import erle_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_REPEAT
) (
  input  logic               open_run,
  input  logic [COUNT_W-1:0] count,
  input  logic [3:0]         digit,
  output logic [COUNT_W-1:0] count_next
);

  logic [COUNT_W-1:0] base;
  logic [COUNT_W+3:0] sum;

  assign base = open_run ? count : '0;
  // x*10 as x*8 + x*2
  assign sum  = ({base, 3'b000} + {2'b00, base, 1'b0}) + (COUNT_W+4)'(digit);
  assign count_next = (sum > (COUNT_W+4)'(MAX_RUN)) ? COUNT_W'(MAX_RUN)
                                                    : sum[COUNT_W-1:0];

endmodule

>>> hdl/erle_out_reg.sv
// output register between the sequencer and the expanded text channel
module erle_out_reg
  import erle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  erle_emit_t emit,
  output logic       free,
  erle_out_if.source expanded
);

  logic              valid;
  logic [BYTE_W-1:0] data;
  logic              last;

  assign free = !valid || expanded.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && emit.valid) begin
      data <= emit.data;
      last <= emit.last;
    end
  end

  assign expanded.valid    = valid;
  assign expanded.out_byte = data;
  assign expanded.out_last = last;

endmodule

>>> hdl/escaped_run_length_expander_unit.sv
// escaped run-length expander: sequencer around a shared count unit
// a backslash is taken while idle; each digit, literal or escaped, passes the digit state
// other bytes pass the close and held states, where bytes are emitted; a closing run too
// throughput: at most one expanded byte per cycle; a stalled output adds its stall cycles
// one request is taken at a time: ready is high only while the sequencer is idle
// rst is synchronous and active high; it clears the sequencer and all text state
module escaped_run_length_expander_unit
  import erle_pkg::*;
#(
  parameter int unsigned MAX_RUN = MAX_REPEAT
) (
  input  logic       clk,
  input  logic       rst,
  erle_in_if.sink    raw,
  erle_out_if.source expanded
);

  // sequencer state
  erle_state_t state, state_next;

  // text state kept between requests
  logic               escape_seen;
  logic               in_number;
  logic [COUNT_W-1:0] count_value;
  logic [BYTE_W-1:0]  last_digit;
  logic               held_valid;
  logic [BYTE_W-1:0]  held_char;

  // current request
  logic [BYTE_W-1:0]  cur_byte;
  logic               cur_last;
  logic               char_pending;  // a non-digit waits to become the held char
  logic               literal;       // digit run fed by a plain ascii digit
  erle_dpos_t         dpos;
  logic [COUNT_W-1:0] rep;           // repeats of the held char already sent

  logic               accept;
  logic               in_is_digit;
  logic [3:0]         digit_sel;
  logic [BYTE_W-1:0]  lit_val;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] rep_inc;
  erle_emit_t         emit;
  logic               free;
  logic               fire;
  erle_dpos_t         start_pos;

  assign raw.ready   = (state == ST_IDLE);
  assign accept      = raw.valid && raw.ready;
  assign in_is_digit = (raw.in_byte >= ASCII_ZERO) && (raw.in_byte <= ASCII_NINE);
  assign start_pos   = (raw.in_byte >= 8'd100) ? DIG_HUND :
                       ((raw.in_byte >= 8'd10) ? DIG_TENS : DIG_ONES);

  // digit fed to the count unit this cycle
  assign lit_val   = cur_byte - ASCII_ZERO;
  assign digit_sel = literal ? lit_val[3:0] : escape_digit(cur_byte, dpos);
  assign rep_inc   = rep + COUNT_W'(1);

  erle_count_unit #(
    .MAX_RUN (MAX_RUN)
  ) u_count (
    .open_run   (in_number),
    .count      (count_value),
    .digit      (digit_sel),
    .count_next (count_next)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (escape_seen) begin
            state_next = ST_DIGIT;
          end else if ((raw.in_byte == BACKSLASH) && !raw.in_last) begin
            state_next = ST_IDLE;
          end else if (in_is_digit) begin
            state_next = ST_DIGIT;
          end else begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_DIGIT: begin
        if (dpos == DIG_ONES) begin
          state_next = cur_last ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        // run fully applied once nothing more is offered
        if (!emit.valid) begin
          state_next = ST_HELD;
        end
      end
      ST_HELD: begin
        if (!held_valid && !(char_pending && cur_last)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // byte offered to the output register; last marks the final byte of a closing text
  always_comb begin
    emit = '0;
    unique case (state)
      ST_CLOSE: begin
        if (in_number && held_valid && (rep != count_value)) begin
          emit.valid = 1'b1;
          emit.data  = held_char;
          emit.last  = cur_last && !char_pending && (rep_inc == count_value);
        end else if (in_number && !held_valid) begin
          // run that opened the text: only its last digit goes out
          emit.valid = 1'b1;
          emit.data  = last_digit;
          emit.last  = cur_last && !char_pending;
        end
      end
      ST_HELD: begin
        if (held_valid) begin
          emit.valid = 1'b1;
          emit.data  = held_char;
          emit.last  = cur_last && !char_pending;
        end
      end
      default: emit = '0;
    endcase
  end

  assign fire = emit.valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // text state and request bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_seen  <= 1'b0;
      in_number    <= 1'b0;
      count_value  <= '0;
      last_digit   <= '0;
      held_valid   <= 1'b0;
      held_char    <= '0;
      char_pending <= 1'b0;
      literal      <= 1'b0;
      dpos         <= DIG_ONES;
      rep          <= '0;
      cur_byte     <= '0;
      cur_last     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_byte <= raw.in_byte;
            cur_last <= raw.in_last;
            rep      <= '0;
            if (escape_seen) begin
              escape_seen <= 1'b0;
              literal     <= 1'b0;
              dpos        <= start_pos;
            end else if ((raw.in_byte == BACKSLASH) && !raw.in_last) begin
              escape_seen <= 1'b1;
            end else if (in_is_digit) begin
              literal <= 1'b1;
              dpos    <= DIG_ONES;
            end else begin
              char_pending <= 1'b1;
            end
          end
        end
        ST_DIGIT: begin
          // one digit through the shared unit per cycle
          in_number   <= 1'b1;
          count_value <= count_next;
          last_digit  <= ASCII_ZERO + BYTE_W'(digit_sel);
          unique case (dpos)
            DIG_HUND: dpos <= DIG_TENS;
            DIG_TENS: dpos <= DIG_ONES;
            default:  dpos <= DIG_ONES;
          endcase
        end
        ST_CLOSE: begin
          if (emit.valid) begin
            if (fire) begin
              if (held_valid) begin
                rep <= rep_inc;
              end else begin
                in_number <= 1'b0;
              end
            end
          end else begin
            // a run consumes the held char, whether repeated or deleted
            if (in_number) begin
              held_valid <= 1'b0;
            end
            in_number   <= 1'b0;
            count_value <= '0;
            rep         <= '0;
          end
        end
        ST_HELD: begin
          if (held_valid) begin
            if (fire) begin
              held_valid <= 1'b0;
            end
          end else if (char_pending) begin
            held_char    <= cur_byte;
            held_valid   <= 1'b1;
            char_pending <= 1'b0;
          end else if (cur_last) begin
            // text closed: text state back to its reset values
            escape_seen <= 1'b0;
            in_number   <= 1'b0;
            count_value <= '0;
            last_digit  <= '0;
            held_valid  <= 1'b0;
            held_char   <= '0;
            cur_last    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  erle_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .free     (free),
    .expanded (expanded)
  );

endmodule

>>> tb/sv/erle_expansion_monitor.sv
// scoreboard that predicts and checks the expanded byte stream of the expander
`timescale 1ns / 1ps
module erle_expansion_monitor
  import erle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  erle_in_if   raw,
  erle_out_if  expanded,
  output int   fails,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } due_byte_t;

  due_byte_t due_bytes[$];
  due_byte_t head;

  // text state of the predicted expander
  logic               esc_pending;
  logic               run_open;
  logic [COUNT_W-1:0] run_count;
  logic [BYTE_W-1:0]  run_digit;
  logic               hold_ok;
  logic [BYTE_W-1:0]  hold_char;

  task automatic clear_text();
    esc_pending = 1'b0;
    run_open    = 1'b0;
    run_count   = '0;
    run_digit   = '0;
    hold_ok     = 1'b0;
    hold_char   = '0;
  endtask

  task automatic add_digit(input logic [3:0] d);
    int v;
    if (!run_open) begin
      run_open  = 1'b1;
      run_count = '0;
    end
    v = int'(run_count) * 10 + int'(d);
    run_count = (v > int'(MAX_REPEAT)) ? COUNT_W'(MAX_REPEAT) : COUNT_W'(v);
    run_digit = ASCII_ZERO + BYTE_W'(d);
  endtask

  // apply an open digit run to the held character, or emit its last digit
  task automatic close_run();
    if (run_open) begin
      if (hold_ok) begin
        for (int i = 0; i < int'(run_count); i++) due_bytes.push_back({hold_char, 1'b0});
        hold_ok = 1'b0;
      end else begin
        due_bytes.push_back({run_digit, 1'b0});
      end
      run_open  = 1'b0;
      run_count = '0;
    end
  endtask

  task automatic expand_byte(input logic [BYTE_W-1:0] b, input logic l);
    int start_size;
    start_size = due_bytes.size();
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (b >= 8'd100) add_digit(4'(b / 8'd100));
      if (b >= 8'd10) add_digit(4'((b / 8'd10) % 8'd10));
      add_digit(4'(b % 8'd10));
    end else if (b == BACKSLASH && !l) begin
      esc_pending = 1'b1;
    end else if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
      add_digit(4'(b - ASCII_ZERO));
    end else begin
      close_run();
      if (hold_ok) due_bytes.push_back({hold_char, 1'b0});
      hold_char = b;
      hold_ok   = 1'b1;
    end
    if (l) begin
      close_run();
      if (hold_ok) due_bytes.push_back({hold_char, 1'b0});
      // a close that emits nothing leaves no last flag
      if (due_bytes.size() > start_size) due_bytes[due_bytes.size()-1].last = 1'b1;
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_text();
      due_bytes.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (raw.valid && raw.ready) expand_byte(raw.in_byte, raw.in_last);
      if (expanded.valid && expanded.ready) begin
        if (due_bytes.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual byte 0x%02h last %0b",
                   $time, expanded.out_byte, expanded.out_last);
        end else begin
          head = due_bytes.pop_front();
          checked++;
          if (expanded.out_byte !== head.data) begin
            fails++;
            $display("%0t: out_byte mismatch, expected 0x%02h, actual 0x%02h",
                     $time, head.data, expanded.out_byte);
          end
          if (expanded.out_last !== head.last) begin
            fails++;
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, head.last, expanded.out_last);
          end
        end
      end
    end
    pending = due_bytes.size();
  end

endmodule

>>> tb/sv/tb_escaped_run_length_expander_unit.sv
// top of the expander testbench: clock, reset, text stimulus and verdict
`timescale 1ns / 1ps
module tb_escaped_run_length_expander_unit
  import erle_pkg::*;
();

  // source bytes in the whole run, directed texts included
  localparam int TOTAL_ITEMS  = 180;
  // worst case is far below this: ~200 bytes, each up to 64 results, each result
  // stalled by the longest receiver gap, plus the long hold-off
  localparam int CYCLE_LIMIT  = 1500000;
  // quiet cycles once nothing is expected, covering a closing byte's latency
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;

  erle_in_if  raw_ch();
  erle_out_if exp_ch();

  int fails;
  int pending;
  int checked;

  // shared between the sender and receiver sides
  bit gaps_on     = 1'b1;
  int hold_cycles = 0;

  int bytes_sent = 0;
  int texts_sent = 0;
  logic [BYTE_W-1:0] text_buf[$];

  escaped_run_length_expander_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw_ch),
    .expanded (exp_ch)
  );

  erle_expansion_monitor u_mon (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw_ch),
    .expanded (exp_ch),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a stuck handshake ends the run here
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // a byte that neither opens a count nor an escape
  function automatic logic [BYTE_W-1:0] pick_plain();
    logic [BYTE_W-1:0] b;
    do begin
      if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(8'h61, 8'h7A));
      else b = 8'($urandom_range(0, 255));
    end while ((b >= ASCII_ZERO && b <= ASCII_NINE) || b == BACKSLASH);
    return b;
  endfunction

  // receiver side: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int stall_left;
    stall_left   = 0;
    exp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        exp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      if (stall_left > 0) begin
        exp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        exp_ch.ready <= 1'b1;
        if (gaps_on) stall_left = pick_gap();
      end
    end
  end

  // offer one source byte, called and returning at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      raw_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_ch.valid   <= 1'b1;
    raw_ch.in_byte <= b;
    raw_ch.in_last <= l;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(BYTE_W'(s[i]));
  endtask

  // send the buffered text with the last flag on its final byte
  task automatic flush_text();
    for (int i = 0; i < text_buf.size(); i++) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
    texts_sent++;
  endtask

  // random text built from plain bytes, counts, escapes, any bytes and stray backslashes
  task automatic make_text();
    int parts;
    int r;
    parts = $urandom_range(1, 6);
    for (int p = 0; p < parts; p++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        text_buf.push_back(pick_plain());
      end else if (r < 60) begin
        text_buf.push_back(ASCII_ZERO + 8'($urandom_range(0, 4)));
        if ($urandom_range(0, 3) == 0) text_buf.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
      end else if (r < 75) begin
        text_buf.push_back(BACKSLASH);
        if ($urandom_range(0, 3) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
        else text_buf.push_back(8'($urandom_range(0, 12)));
      end else if (r < 95) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        // may end up as the final byte and be taken literally
        text_buf.push_back(BACKSLASH);
      end
    end
  endtask

  // let the block settle before the sender resumes
  task automatic drain();
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int rnd_text;
    raw_ch.valid   = 1'b0;
    raw_ch.in_byte = '0;
    raw_ch.in_last = 1'b0;
    rst = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed texts
    push_str("a");       flush_text();  // single character text
    push_str("0");       flush_text();  // count opening a text gives its digit
    push_str("x3y");     flush_text();  // plain repeat
    push_str("q05");     flush_text();  // leading zero, count ends the text
    push_str("z99");     flush_text();  // count saturates at the maximum
    push_str("\\");      flush_text();  // backslash as the final byte is literal
    push_str("k\\");
    text_buf.push_back(8'hFF);
    flush_text();                       // escaped final byte, saturated count
    text_buf.push_back(8'hFF);
    text_buf.push_back(BACKSLASH);
    text_buf.push_back(8'h00);
    flush_text();                       // escaped zero deletes, close emits nothing
    push_str("12");
    text_buf.push_back(8'h00);
    flush_text();                       // leading run, then a zero byte character

    drain();

    // random texts with both pressure cases and a quiet stretch
    rnd_text = 0;
    while (bytes_sent < TOTAL_ITEMS) begin
      if (rnd_text == 2) hold_cycles = 300;  // receiver holds off, sender keeps going
      if (rnd_text == 8) drain();            // sender waits for every result
      gaps_on = !(rnd_text >= 10 && rnd_text < 14);
      make_text();
      flush_text();
      rnd_text++;
    end
    raw_ch.valid <= 1'b0;
    gaps_on = 1'b1;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d texts, %0d source bytes, %0d expanded bytes compared",
             texts_sent, bytes_sent, checked);
    $display("summary: escapes, saturated and zero counts, leading runs, empty closes");
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/erle_pkg.sv
hdl/erle_in_if.sv
hdl/erle_out_if.sv
hdl/erle_count_unit.sv
hdl/erle_out_reg.sv
hdl/escaped_run_length_expander_unit.sv
tb/sv/erle_expansion_monitor.sv
tb/sv/tb_escaped_run_length_expander_unit.sv
